@@ hw/rtl/ccss_pkg.sv @@
// Package: shared types and constants for the constant-current soft-start regulator
`default_nettype none
package ccss_pkg;

  localparam logic [7:0]  DUTY_TOP    = 8'd255;
  localparam logic [7:0]  DUTY_MIN    = 8'd0;
  localparam logic [11:0] CURRENT_MAX = 12'd4095;
  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [19:0] PCT_SCALE   = 20'd100;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [1:0] {
    MODE_SOFT = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SNUB = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_CURRENT     = 3'd0,
    CFG_RIPPLE_LIMIT       = 3'd1,
    CFG_SOFT_STEP_CURRENT  = 3'd2,
    CFG_SOFT_PERIOD        = 3'd3,
    CFG_SNUB_PERCENT       = 3'd4,
    CFG_VOLTAGE_LIMIT      = 3'd5,
    CFG_VOLTAGE_HYSTERESIS = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] measured_current;
    logic [14:0] measured_voltage;
    logic        output_enable;
    logic        cv_snubbing;
    logic [15:0] time_ticks;
  } req_t;

endpackage
`default_nettype wire

@@ hw/rtl/ccss_req_if.sv @@
// Interface: request channel carrying one regulation tick
`default_nettype none
interface ccss_req_if;
  logic        valid;
  logic        ready;
  logic [11:0] measured_current;
  logic [14:0] measured_voltage;
  logic        output_enable;
  logic        cv_snubbing;
  logic [15:0] time_ticks;

  modport source (
    output valid, measured_current, measured_voltage, output_enable, cv_snubbing, time_ticks,
    input  ready
  );
  modport sink (
    input  valid, measured_current, measured_voltage, output_enable, cv_snubbing, time_ticks,
    output ready
  );
endinterface
`default_nettype wire

@@ hw/rtl/ccss_rsp_if.sv @@
// Interface: response channel carrying duty, mode and flags of one tick
`default_nettype none
interface ccss_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_value;
  logic [1:0] regulator_mode;
  logic       error_flag;
  logic       cv_handoff;

  modport source (
    output valid, duty_value, regulator_mode, error_flag, cv_handoff,
    input  ready
  );
  modport sink (
    input  valid, duty_value, regulator_mode, error_flag, cv_handoff,
    output ready
  );
endinterface
`default_nettype wire

@@ hw/rtl/constant_current_softstart_regulator.sv @@
// Top level: constant-current soft-start regulator with input and result registers
// Path: an accepted request is held in the input register; its duty, mode and
//   flags are then registered in the result register, which drives the response.
// Throughput: one request per cycle while responses are taken; an empty input
//   register takes a new request while a response waits in the result register.
// Reset (rst, synchronous): clears both stages, loads the register defaults,
//   duty 0, soft start mode, error 0, last current at full scale, last step time 0.
`default_nettype none
module constant_current_softstart_regulator
  import ccss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  ccss_req_if.sink                   req,
  ccss_rsp_if.source                 rsp
);

  logic [11:0] target_current;
  logic [11:0] ripple_limit;
  logic [11:0] soft_step_current;
  logic [7:0]  soft_period;
  logic [6:0]  snub_percent;
  logic [14:0] voltage_limit;
  logic [11:0] voltage_hysteresis;

  logic  s1_valid;
  req_t  s1;

  logic [7:0]  duty;
  mode_t       mode;
  logic        error;
  logic [11:0] last_current;
  logic [15:0] last_soft_time;

  logic [7:0]  duty_next;
  mode_t       mode_next;
  logic        error_next;
  logic [11:0] last_current_next;
  logic [15:0] last_soft_time_next;
  logic        handoff_next;

  logic        out_valid;
  logic [7:0]  out_duty;
  mode_t       out_mode;
  logic        out_error;
  logic        out_handoff;

  logic advance;
  logic out_free;

  logic        trip;
  logic        volt_high;
  logic [6:0]  pct_clamped;
  logic [18:0] snub_product;
  logic [19:0] snub_lhs;
  logic        snub_exit;
  logic [15:0] elapsed;
  logic        period_done;
  logic        rise_ok;

  assign out_free  = !out_valid || rsp.ready;
  assign advance   = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_current     <= 12'd20;
      ripple_limit       <= 12'd1000;
      soft_step_current  <= 12'd1;
      soft_period        <= 8'd5;
      snub_percent       <= 7'd3;
      voltage_limit      <= 15'd5000;
      voltage_hysteresis <= 12'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_CURRENT:     target_current     <= cfg_data[11:0];
        CFG_RIPPLE_LIMIT:       ripple_limit       <= cfg_data[11:0];
        CFG_SOFT_STEP_CURRENT:  soft_step_current  <= cfg_data[11:0];
        CFG_SOFT_PERIOD:        soft_period        <= cfg_data[7:0];
        CFG_SNUB_PERCENT:       snub_percent       <= cfg_data[6:0];
        CFG_VOLTAGE_LIMIT:      voltage_limit      <= cfg_data[14:0];
        CFG_VOLTAGE_HYSTERESIS: voltage_hysteresis <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1.measured_current <= req.measured_current;
      s1.measured_voltage <= req.measured_voltage;
      s1.output_enable    <= req.output_enable;
      s1.cv_snubbing      <= req.cv_snubbing;
      s1.time_ticks       <= req.time_ticks;
    end
  end

  assign trip = (mode == MODE_ON) &&
                ({1'b0, s1.measured_current} > ({1'b0, target_current} + {1'b0, ripple_limit}));
  assign volt_high = ({1'b0, s1.measured_voltage} >=
                      ({1'b0, voltage_limit} + {4'b0, voltage_hysteresis}));
  assign pct_clamped  = (snub_percent > PCT_FULL) ? PCT_FULL : snub_percent;
  assign snub_product = {7'b0, target_current} * {12'b0, PCT_FULL - pct_clamped};
  assign snub_lhs     = ({8'b0, s1.measured_current} + 20'd1) * PCT_SCALE;
  assign snub_exit    = snub_lhs <= {1'b0, snub_product};
  assign elapsed      = s1.time_ticks - last_soft_time;
  assign period_done  = elapsed >= {8'b0, soft_period};
  assign rise_ok      = {1'b0, s1.measured_current} <=
                        ({1'b0, last_current} + {1'b0, soft_step_current});

  always_comb begin
    logic cont;
    duty_next           = duty;
    mode_next           = mode;
    error_next          = error;
    last_current_next   = last_current;
    last_soft_time_next = last_soft_time;
    handoff_next        = 1'b0;
    cont                = 1'b0;

    if (trip) begin
      duty_next  = DUTY_MIN;
      mode_next  = MODE_SNUB;
      error_next = 1'b1;
    end

    if (s1.output_enable) begin
      if (volt_high || s1.cv_snubbing) begin
        handoff_next = 1'b1;
      end else begin
        cont = 1'b1;
        if (mode_next == MODE_SNUB) begin
          if (snub_exit) begin
            if (snub_percent == 7'd0) begin
              mode_next  = MODE_ON;
              error_next = 1'b0;
            end else begin
              duty_next = DUTY_MIN;
              mode_next = MODE_SOFT;
            end
          end else begin
            cont = 1'b0;
          end
        end

        if (cont) begin
          if (s1.measured_current < target_current && duty_next < DUTY_TOP) begin
            if (mode_next == MODE_SOFT) begin
              if (period_done) begin
                last_soft_time_next = s1.time_ticks;
                if (rise_ok) begin
                  duty_next = duty_next + 8'd1;
                end
              end
            end else begin
              duty_next = duty_next + 8'd1;
            end
          end else if (s1.measured_current > target_current && duty_next > DUTY_MIN) begin
            duty_next = duty_next - 8'd1;
            if (mode_next == MODE_SOFT) begin
              mode_next  = MODE_ON;
              error_next = 1'b0;
            end
          end

          if (s1.measured_current >= target_current || duty_next == DUTY_TOP) begin
            if (mode_next == MODE_SOFT) begin
              mode_next  = MODE_ON;
              error_next = 1'b0;
            end
          end

          last_current_next = s1.measured_current;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty           <= DUTY_MIN;
      mode           <= MODE_SOFT;
      error          <= 1'b0;
      last_current   <= CURRENT_MAX;
      last_soft_time <= 16'd0;
    end else if (advance) begin
      duty           <= duty_next;
      mode           <= mode_next;
      error          <= error_next;
      last_current   <= last_current_next;
      last_soft_time <= last_soft_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_duty    <= duty_next;
      out_mode    <= mode_next;
      out_error   <= error_next;
      out_handoff <= handoff_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.duty_value     = out_duty;
  assign rsp.regulator_mode = out_mode;
  assign rsp.error_flag     = out_error;
  assign rsp.cv_handoff     = out_handoff;

`ifndef ASSERT_OFF
  a_duty_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> (duty == $past(duty) || duty == $past(duty) + 8'd1 ||
                 duty == $past(duty) - 8'd1 || duty == DUTY_MIN))
    else $error("duty moved by more than one step");

  a_error_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(error) |-> mode == MODE_SNUB)
    else $error("error flag set outside snub");

  a_snub_duty: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_SNUB |-> duty == DUTY_MIN)
    else $error("nonzero duty in snub");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(duty) && $stable(mode) && $stable(last_soft_time))
    else $error("state changed without a request");
`endif

endmodule
`default_nettype wire
